// ----- src/sdpc_pkg.sv -----
// Shared types, request codes and the coil table of the stepper drive core.
package sdpc_pkg;

  typedef enum logic [2:0] {
    REQ_NONE    = 3'd0,
    REQ_FASTER  = 3'd1,
    REQ_SLOWER  = 3'd2,
    REQ_REVERSE = 3'd3,
    REQ_PULSE   = 3'd4,
    REQ_WINDOW  = 3'd5
  } req_code_t;

  typedef enum logic [1:0] {
    CFG_FASTEST = 2'd0,
    CFG_SLOWEST = 2'd1,
    CFG_DELTA   = 2'd2
  } cfg_index_t;

  localparam int PERIOD_BITS = 5;
  localparam int DELTA_BITS  = 4;
  localparam int PHASE_BITS  = 2;
  localparam int COIL_BITS   = 4;
  localparam int FIELD_BITS  = 16;

  localparam logic [PERIOD_BITS-1:0] FASTEST_RESET = 5'd4;
  localparam logic [PERIOD_BITS-1:0] SLOWEST_RESET = 5'd16;
  localparam logic [DELTA_BITS-1:0]  DELTA_RESET   = 4'd2;

  // Control for one saturating pulse counter.
  typedef struct packed {
    logic inc;
    logic clear;
  } cnt_ctrl_t;

  // Wave drive order: phase 0 drives the highest coil.
  function automatic logic [COIL_BITS-1:0] coil_of(input logic [PHASE_BITS-1:0] idx);
    logic [COIL_BITS-1:0] pat;
    unique case (idx)
      2'd0:    pat = 4'h8;
      2'd1:    pat = 4'h4;
      2'd2:    pat = 4'h2;
      default: pat = 4'h1;
    endcase
    return pat;
  endfunction

endpackage

// ----- src/sdpc_sat_counter.sv -----
// Saturating event counter with synchronous clear.
module sdpc_sat_counter
  import sdpc_pkg::*;
#(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  cnt_ctrl_t        ctrl,
  output logic [WIDTH-1:0] count
);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.clear) begin
      count <= '0;
    end else if (ctrl.inc && (count != {WIDTH{1'b1}})) begin
      count <= count + WIDTH'(1);
    end
  end

endmodule

// ----- src/stepper_drive_with_pulse_counter_core.sv -----
// Stepper wave-drive controller with period control and encoder pulse counters.
// Result: registered; result_valid rises in the cycle after its request is accepted.
// Throughput: one request per cycle; the state registers act as the result
// register and are held while a result waits, so only that stall holds requests.
// Reset: period 4, forward direction, phase 0 (coil 8), all counters cleared,
// limits 4 and 16 and step change 2; configuration writes are always taken.
module stepper_drive_with_pulse_counter_core
  import sdpc_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  logic [2:0]             req_type,
  input  logic                   tick,
  input  logic                   encoder_level,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic [COIL_BITS-1:0]   coil_pattern,
  output logic                   reverse_mode,
  output logic [PERIOD_BITS-1:0] current_period,
  output logic [FIELD_BITS-1:0]  forward_pulses,
  output logic [FIELD_BITS-1:0]  backward_pulses,
  output logic [FIELD_BITS-1:0]  measured_speed,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [PERIOD_BITS-1:0] cfg_data
);

  logic [PERIOD_BITS-1:0] fastest_period;
  logic [PERIOD_BITS-1:0] slowest_period;
  logic [DELTA_BITS-1:0]  period_delta;

  logic [PERIOD_BITS-1:0] step_period, step_period_next;
  logic                   requested_reverse, requested_reverse_next;
  logic                   group_reverse, group_reverse_next;
  logic [PHASE_BITS-1:0]  phase_index, phase_index_next;
  logic [PERIOD_BITS-1:0] tick_count, tick_count_next;

  logic [COUNT_BITS-1:0]  forward_total;
  logic [COUNT_BITS-1:0]  backward_total;
  logic [COUNT_BITS-1:0]  window_total;
  logic [COUNT_BITS-1:0]  speed_value;

  logic                   accept;
  logic [PERIOD_BITS:0]   lower_sum;
  logic [PERIOD_BITS:0]   upper_sum;
  logic [PERIOD_BITS:0]   elapsed;
  logic [PHASE_BITS-1:0]  coil_idx;
  cnt_ctrl_t              fwd_ctrl, bwd_ctrl, win_ctrl;

  assign cfg_ready  = 1'b1;
  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fastest_period <= FASTEST_RESET;
      slowest_period <= SLOWEST_RESET;
      period_delta   <= DELTA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FASTEST: fastest_period <= cfg_data;
        CFG_SLOWEST: slowest_period <= cfg_data;
        CFG_DELTA:   period_delta   <= cfg_data[DELTA_BITS-1:0];
        default:     ;
      endcase
    end
  end

  assign lower_sum = {1'b0, fastest_period} + (PERIOD_BITS+1)'(period_delta);
  assign upper_sum = {1'b0, step_period} + (PERIOD_BITS+1)'(period_delta);

  // The event is applied first; the tick then sees the updated period.
  always_comb begin
    step_period_next       = step_period;
    requested_reverse_next = requested_reverse;
    unique case (req_type)
      REQ_FASTER: begin
        if ({1'b0, step_period} >= lower_sum) begin
          step_period_next = step_period - PERIOD_BITS'(period_delta);
        end
      end
      REQ_SLOWER: begin
        if (upper_sum <= {1'b0, slowest_period}) begin
          step_period_next = upper_sum[PERIOD_BITS-1:0];
        end
      end
      REQ_REVERSE: requested_reverse_next = !requested_reverse;
      default: ;
    endcase

    elapsed            = {1'b0, tick_count} + (PERIOD_BITS+1)'(1);
    tick_count_next    = tick_count;
    phase_index_next   = phase_index;
    group_reverse_next = group_reverse;
    if (tick) begin
      if (elapsed >= {1'b0, step_period_next}) begin
        tick_count_next  = '0;
        phase_index_next = phase_index + PHASE_BITS'(1);
        // A new four-step group picks up the requested direction.
        if (phase_index_next == '0) begin
          group_reverse_next = requested_reverse_next;
        end
      end else begin
        tick_count_next = elapsed[PERIOD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_period       <= FASTEST_RESET;
      requested_reverse <= 1'b0;
      group_reverse     <= 1'b0;
      phase_index       <= '0;
      tick_count        <= '0;
      speed_value       <= '0;
      result_valid      <= 1'b0;
    end else begin
      if (accept) begin
        step_period       <= step_period_next;
        requested_reverse <= requested_reverse_next;
        group_reverse     <= group_reverse_next;
        phase_index       <= phase_index_next;
        tick_count        <= tick_count_next;
        if (req_type == REQ_WINDOW) begin
          speed_value <= window_total;
        end
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    fwd_ctrl.inc   = accept && (req_type == REQ_PULSE) && encoder_level;
    fwd_ctrl.clear = 1'b0;
    bwd_ctrl.inc   = accept && (req_type == REQ_PULSE) && !encoder_level;
    bwd_ctrl.clear = 1'b0;
    win_ctrl.inc   = accept && (req_type == REQ_PULSE);
    win_ctrl.clear = accept && (req_type == REQ_WINDOW);
  end

  sdpc_sat_counter #(.WIDTH(COUNT_BITS)) u_fwd_count (
    .clk  (clk),
    .rst  (rst),
    .ctrl (fwd_ctrl),
    .count(forward_total)
  );

  sdpc_sat_counter #(.WIDTH(COUNT_BITS)) u_bwd_count (
    .clk  (clk),
    .rst  (rst),
    .ctrl (bwd_ctrl),
    .count(backward_total)
  );

  sdpc_sat_counter #(.WIDTH(COUNT_BITS)) u_win_count (
    .clk  (clk),
    .rst  (rst),
    .ctrl (win_ctrl),
    .count(window_total)
  );

  // State only moves on an accepted request, so it holds a waiting result.
  assign coil_idx        = group_reverse ? ~phase_index : phase_index;
  assign coil_pattern    = coil_of(coil_idx);
  assign reverse_mode    = requested_reverse;
  assign current_period  = step_period;
  assign forward_pulses  = FIELD_BITS'(forward_total);
  assign backward_pulses = FIELD_BITS'(backward_total);
  assign measured_speed  = FIELD_BITS'(speed_value);

  a_coil_onehot: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot(coil_pattern))
    else $error("coil drive is not one-hot");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> result_valid)
    else $error("accepted request produced no result");

  a_window_copy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && req_type == REQ_WINDOW)
      |=> (speed_value == $past(window_total)) && (window_total == '0))
    else $error("window end did not copy and clear the window total");

endmodule
